[design/weighted_class_score_averager_top_macros.svh]
// assertion macros for the weighted class score averager
`ifndef WEIGHTED_CLASS_SCORE_AVERAGER_TOP_MACROS_SVH
`define WEIGHTED_CLASS_SCORE_AVERAGER_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define WCSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define WCSA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[design/wcsa_pkg.sv]
// package of the weighted class score averager: widths, constants, types
`default_nettype none
package wcsa_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int VAL_W           = 17;
  localparam int CLS_IN_W        = 5;
  localparam int SUM_W           = 48;
  localparam int MASS_W          = 27;
  localparam int RATIO_W         = 21;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 5;
  localparam int NUM_CLASSES_DEF = 32;
  localparam int MAX_DET_DEF     = 1024;

  localparam logic [VAL_W-1:0]   ONE_Q     = VAL_W'(1 << FRAC_BITS);
  localparam logic [RATIO_W-1:0] RATIO_CAP = RATIO_W'(1 << (FRAC_BITS + 4));
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [MASS_W-1:0]  MASS_MAX  = {MASS_W{1'b1}};

  // divide by ten as multiply by ceil(2^23 / 10) and shift, exact below 2^22
  localparam logic [19:0] FACT_RECIP = 20'd838861;
  localparam int          FACT_SHIFT = 23;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BY_CONF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_BY_CONF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_EN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_IDX     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_PREP,
    ST_MEAN_W,
    ST_FACT_ST,
    ST_SCAN,
    ST_DIV_ST,
    ST_DIV_W,
    ST_FIN,
    ST_OUT,
    ST_CLR
  } state_e;

  // request to the shared divider
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [MASS_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

[design/wcsa_div.sv]
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module wcsa_div
  import wcsa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire div_req_t         req_i,
  output logic                  busy_o,
  output logic [SUM_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(SUM_W);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  dq_q, dq_d;
  logic [MASS_W-1:0] rem_q, rem_d;
  logic [MASS_W-1:0] dvs_q, dvs_d;
  logic [MASS_W:0]   shifted;
  logic              take;

  // one restoring step
  always_comb begin
    shifted = {rem_q, dq_q[SUM_W-1]};
    take    = (shifted >= {1'b0, dvs_q});
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SUM_W - 1);
      dq_d   = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = take ? MASS_W'(shifted - {1'b0, dvs_q}) : shifted[MASS_W-1:0];
      dq_d  = {dq_q[SUM_W-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dq_q;

endmodule
`default_nettype wire

[design/weighted_class_score_averager_top.sv]
// Weighted class score averager, top level.
// Input channel: one word per class score of a detection (in_valid_i / in_stall_o),
// with flags for end of detection and end of set. Output channel (out_valid_o /
// out_stall_i): one word per class seen, in ascending class order, last_o on the
// final word of a set. Configuration is a write port (cfg_we_i, cfg_idx_i,
// cfg_data_i), to be written only while the block is idle; the block itself
// does not enforce this. An input word is accepted, its sum read and written back
// before the next is taken; in_stall_o is high from acceptance until idle again.
// End of set: when scaling, the mean confidence is prepared, divided on the shared
// divider and made a factor by a reciprocal multiply on the shared multiplier,
// else the block goes straight to the scan. The classes are then scanned in
// ascending order; a seen class is divided by its mass (skipped with zero mass),
// multiplied by the factor, and waits until its output word is taken. A set that
// saw nothing emits no word. State is cleared after the run. The output register
// holds its word while out_stall_i is high, and the block waits. Reset clears
// flags, masses, counts and configuration at once; the sum memory is not reset,
// an entry reads as zero until its seen flag is set, so no clearing pass is needed.
`default_nettype none
`include "weighted_class_score_averager_top_macros.svh"
module weighted_class_score_averager_top
  import wcsa_pkg::*;
#(
  parameter int NUM_CLASSES    = NUM_CLASSES_DEF,
  parameter int MAX_DETECTIONS = MAX_DET_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [CLS_IN_W-1:0]   class_index_i,
  input  wire logic [VAL_W-1:0]      class_score_i,
  input  wire logic [VAL_W-1:0]      confidence_i,
  input  wire logic                  single_class_i,
  input  wire logic                  no_score_i,
  input  wire logic                  end_of_detection_i,
  input  wire logic                  end_of_set_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [CLS_IN_W-1:0]        out_class_o,
  output logic [VAL_W-1:0]           out_score_o,
  output logic                       last_o
);

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W = $clog2(MAX_DETECTIONS + 1);
  localparam int EXT_W = 7;
  localparam int MUL_A = RATIO_W;
  localparam int MUL_B = MASS_W;

  state_e state_q, state_d;

  // configuration
  logic                wbc_q, sbc_q, ign_en_q;
  logic [CLS_IN_W-1:0] ign_idx_q;

  // captured input word
  logic                it_single_q, it_none_q, it_eod_q, it_eos_q;
  logic [CLS_IN_W-1:0] it_cls_q;
  logic [VAL_W-1:0]    it_score_q, it_conf_q;

  // accumulation state
  logic [SUM_W-1:0]       sums_mem [NUM_CLASSES];
  logic [SUM_W-1:0]       rd_q;
  logic [NUM_CLASSES-1:0] seen_q;
  logic [SUM_W-1:0]       ign_sum_q;
  logic [MASS_W-1:0]      non_ign_mass_q, ign_mass_q, conf_sum_q;
  logic [CNT_W-1:0]       cnt_q;

  // end-of-set state
  logic [MASS_W-1:0] mass_q, factor_q;
  logic              ign_only_q;
  logic [CLS_W-1:0]  scan_q;
  logic [SUM_W-1:0]  prod_q;

  // output register
  logic                out_valid_q, last_q;
  logic [CLS_IN_W-1:0] out_class_q;
  logic [VAL_W-1:0]    out_score_q;

  // combinational
  logic                   in_acc, out_acc;
  logic                   active, is_ign, cls_ok, ign_ok;
  logic [VAL_W-1:0]       weight;
  logic [CLS_W-1:0]       it_addr, rd_addr;
  logic [SUM_W-1:0]       old_sum;
  logic [SUM_W:0]         sum_add, ign_add;
  logic [MASS_W:0]        nim_add, im_add, cs_add;
  logic [NUM_CLASSES-1:0] seen_eff;
  logic                   later_seen, scan_end;
  logic [MUL_A-1:0]       mul_a;
  logic [MUL_B-1:0]       mul_b;
  logic [SUM_W-1:0]       mul_p;
  logic [RATIO_W-1:0]     ratio;
  logic [SUM_W-1:0]       scan_sum;
  logic [MUL_A-1:0]       fact_num;
  logic [SUM_W-FRAC_BITS-1:0] scaled;
  div_req_t               div_req;
  logic                   div_busy;
  logic [SUM_W-1:0]       div_quot;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  // per-word decode
  assign active  = cnt_q < CNT_W'(MAX_DETECTIONS);
  assign weight  = wbc_q ? it_conf_q : ONE_Q;
  assign is_ign  = ign_en_q && it_single_q && !it_none_q && (it_cls_q == ign_idx_q);
  assign cls_ok  = EXT_W'(it_cls_q) < EXT_W'(NUM_CLASSES);
  assign ign_ok  = EXT_W'(ign_idx_q) < EXT_W'(NUM_CLASSES);
  assign it_addr = CLS_W'(it_cls_q);
  assign rd_addr = (state_q == ST_SCAN) ? scan_q : it_addr;
  assign old_sum = seen_q[it_addr] ? rd_q : '0;
  assign sum_add = {1'b0, old_sum} + {1'b0, prod_q};
  assign ign_add = {1'b0, ign_sum_q} + {1'b0, prod_q};
  assign nim_add = {1'b0, non_ign_mass_q} + (MASS_W + 1)'(weight);
  assign im_add  = {1'b0, ign_mass_q} + (MASS_W + 1)'(weight);
  assign cs_add  = {1'b0, conf_sum_q} + (MASS_W + 1)'(it_conf_q);

  // classes to emit, and whether any follows the current one
  always_comb begin
    seen_eff   = seen_q;
    later_seen = 1'b0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (ign_only_q && ign_ok && (EXT_W'(ign_idx_q) == EXT_W'(i))) begin
        seen_eff[i] = 1'b1;
      end
    end
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (seen_eff[i] && (EXT_W'(i) > EXT_W'(scan_q))) begin
        later_seen = 1'b1;
      end
    end
  end

  // mean confidence is below 2^17, so the factor numerator fits 21 bits
  assign scan_end = (scan_q == CLS_W'(NUM_CLASSES - 1));
  assign scan_sum = (ign_only_q && (EXT_W'(scan_q) == EXT_W'(ign_idx_q))) ? ign_sum_q : rd_q;
  assign ratio    = (div_quot > SUM_W'(RATIO_CAP)) ? RATIO_CAP : div_quot[RATIO_W-1:0];
  assign fact_num = MUL_A'(ONE_Q) + MUL_A'({div_quot[VAL_W-1:0], 3'b000})
                  + MUL_A'(div_quot[VAL_W-1:0]);
  assign scaled   = prod_q[SUM_W-1:FRAC_BITS];

  // shared multiplier: score times weight, factor numerator times reciprocal,
  // or ratio times factor
  always_comb begin
    if (state_q == ST_RD) begin
      mul_a = MUL_A'(it_score_q);
      mul_b = MUL_B'(weight);
    end else if (state_q == ST_FACT_ST) begin
      mul_a = fact_num;
      mul_b = MUL_B'(FACT_RECIP);
    end else begin
      mul_a = ratio;
      mul_b = factor_q;
    end
  end
  assign mul_p = SUM_W'(mul_a * mul_b);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_RD;
      ST_RD:      state_d = ST_WR;
      ST_WR:      state_d = it_eos_q ? ST_PREP : ST_IDLE;
      ST_PREP:    state_d = (sbc_q && (cnt_q != '0)) ? ST_MEAN_W : ST_SCAN;
      ST_MEAN_W:  if (!div_busy) state_d = ST_FACT_ST;
      ST_FACT_ST: state_d = ST_SCAN;
      ST_SCAN: begin
        if (seen_eff[scan_q]) begin
          state_d = ST_DIV_ST;
        end else if (scan_end) begin
          state_d = ST_CLR;
        end
      end
      ST_DIV_ST:  state_d = (mass_q == '0) ? ST_FIN : ST_DIV_W;
      ST_DIV_W:   if (!div_busy) state_d = ST_FIN;
      ST_FIN:     state_d = ST_OUT;
      ST_OUT:     if (out_acc) state_d = last_q ? ST_CLR : ST_SCAN;
      ST_CLR:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_q)
      ST_PREP: begin
        div_req.start    = sbc_q && (cnt_q != '0);
        div_req.dividend = SUM_W'(conf_sum_q);
        div_req.divisor  = MASS_W'(cnt_q);
      end
      ST_DIV_ST: begin
        div_req.start    = (mass_q != '0);
        div_req.dividend = scan_sum;
        div_req.divisor  = mass_q;
      end
      default: div_req = '0;
    endcase
  end

  wcsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  // class sum memory
  always_ff @(posedge clk_i) begin
    rd_q <= sums_mem[rd_addr];
    if ((state_q == ST_WR) && active && !it_none_q && !is_ign && cls_ok) begin
      sums_mem[it_addr] <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbc_q     <= 1'b0;
      sbc_q     <= 1'b0;
      ign_en_q  <= 1'b0;
      ign_idx_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WEIGHT_BY_CONF: wbc_q     <= cfg_data_i[0];
        CFG_SCALE_BY_CONF:  sbc_q     <= cfg_data_i[0];
        CFG_IGNORE_EN:      ign_en_q  <= cfg_data_i[0];
        CFG_IGNORE_IDX:     ign_idx_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // control and accumulation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      seen_q         <= '0;
      ign_sum_q      <= '0;
      non_ign_mass_q <= '0;
      ign_mass_q     <= '0;
      conf_sum_q     <= '0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
      scan_q         <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_WR: begin
          if (active && !it_none_q) begin
            if (is_ign) begin
              ign_sum_q <= ign_add[SUM_W] ? SUM_MAX : ign_add[SUM_W-1:0];
            end else if (cls_ok) begin
              seen_q[it_addr] <= 1'b1;
            end
          end
          if (active && it_eod_q) begin
            if (is_ign) begin
              ign_mass_q <= im_add[MASS_W] ? MASS_MAX : im_add[MASS_W-1:0];
            end else begin
              non_ign_mass_q <= nim_add[MASS_W] ? MASS_MAX : nim_add[MASS_W-1:0];
            end
            conf_sum_q <= cs_add[MASS_W] ? MASS_MAX : cs_add[MASS_W-1:0];
            cnt_q      <= cnt_q + 1'b1;
          end
          scan_q <= '0;
        end
        ST_SCAN: begin
          if (!seen_eff[scan_q] && !scan_end) begin
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_FIN: out_valid_q <= 1'b1;
        ST_OUT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (!last_q) begin
              scan_q <= scan_q + 1'b1;
            end
          end
        end
        ST_CLR: begin
          seen_q         <= '0;
          ign_sum_q      <= '0;
          non_ign_mass_q <= '0;
          ign_mass_q     <= '0;
          conf_sum_q     <= '0;
          cnt_q          <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      it_cls_q    <= class_index_i;
      it_score_q  <= class_score_i;
      it_conf_q   <= confidence_i;
      it_single_q <= single_class_i;
      it_none_q   <= no_score_i;
      it_eod_q    <= end_of_detection_i;
      it_eos_q    <= end_of_set_i;
    end
    if (state_q == ST_RD) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_PREP) begin
      factor_q   <= MASS_W'(ONE_Q);
      ign_only_q <= (ign_mass_q != '0) && (non_ign_mass_q == '0);
      mass_q     <= ((ign_mass_q != '0) && (non_ign_mass_q == '0)) ? ign_mass_q
                                                                    : non_ign_mass_q;
    end
    if (state_q == ST_FACT_ST) begin
      factor_q <= MASS_W'(mul_p[SUM_W-1:FACT_SHIFT]);
    end
    if (state_q == ST_DIV_ST) begin
      prod_q <= '0;
    end
    if ((state_q == ST_DIV_W) && !div_busy) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_FIN) begin
      out_class_q <= CLS_IN_W'(scan_q);
      out_score_q <= (scaled > (SUM_W - FRAC_BITS)'(ONE_Q)) ? ONE_Q : scaled[VAL_W-1:0];
      last_q      <= !later_seen;
    end
    if (state_q == ST_CLR) begin
      ign_only_q <= 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_class_o = out_class_q;
  assign out_score_o = out_score_q;
  assign last_o      = last_q;

  // checks on the sequencer
  `WCSA_ASSERT(a_out_in_out_state, out_valid_o |-> (state_q == ST_OUT), "word shown outside output state")
  `WCSA_ASSERT(a_clear_empties, (state_q == ST_CLR) |=> (seen_q == '0 && cnt_q == '0), "state not cleared after run")
  `WCSA_NEVER(a_div_owner, div_busy && !(state_q == ST_MEAN_W || state_q == ST_DIV_W), "divider busy outside a wait state")

endmodule
`default_nettype wire
